[hdl/arff_pkg.sv]
`timescale 1ns / 1ps

package arff_pkg;

	// default surface geometry
	localparam int unsigned SIDE_DEF      = 256;
	localparam int unsigned GRID_STEP_DEF = 16;

	// stream payload widths
	localparam int unsigned DIM_W   = 8;
	localparam int unsigned S_DATA_W = 16;
	localparam int unsigned M_DATA_W = 16;

	// result status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// sequencer states, one-hot
	typedef enum logic [7:0] {
		ST_CLEAR    = 8'b0000_0001,
		ST_IDLE     = 8'b0000_0010,
		ST_CAND     = 8'b0000_0100,
		ST_SCAN_RD  = 8'b0000_1000,
		ST_SCAN_CHK = 8'b0001_0000,
		ST_MARK_RD  = 8'b0010_0000,
		ST_MARK_WR  = 8'b0100_0000,
		ST_OUT      = 8'b1000_0000
	} arff_state_t;

	// one access to the bitmap row memory
	typedef struct packed {
		logic en;
		logic we;
	} arff_mem_ctl_t;

endpackage

[hdl/arff_bitmap.sv]
`timescale 1ns / 1ps

module arff_bitmap #(
	parameter int unsigned SIDE = arff_pkg::SIDE_DEF
) (
	input  logic                       clk,
	input  arff_pkg::arff_mem_ctl_t    ctl,
	input  logic [$clog2(SIDE)-1:0]    addr,
	input  logic [SIDE-1:0]            wdata,
	output logic [SIDE-1:0]            rdata
);
	import arff_pkg::*;

	// one row of the occupancy bitmap per word
	logic [SIDE-1:0] mem [SIDE];
	logic [SIDE-1:0] rdata_q;

	// single port: write or registered read
	always_ff @(posedge clk) begin
		if (ctl.en && ctl.we) begin
			mem[addr] <= wdata;
		end else if (ctl.en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/atlas_rect_first_fit_allocator.sv]
`timescale 1ns / 1ps

// channel | direction | tdata (low bit up)              | tuser
// s_axis  | in        | rect_width[7:0], rect_height[7:0] | -
// m_axis  | out       | origin_x[7:0], origin_y[7:0]     | status
//
// after reset a clearing pass writes every bitmap row, with s_tready low
// per item: an accept step, a candidate step per origin tried (also per candidate row that
// runs off the right edge, and when the scan runs off the bottom), a read and a check per row
// examined until a used pixel is seen, a read and a write per row marked, then a hand-over
// step; the single-port row memory and its masked compare shape this sequence
// s_tready is high only between items; a result waits in the output register until taken

module atlas_rect_first_fit_allocator #(
	parameter int unsigned SIDE      = arff_pkg::SIDE_DEF,
	parameter int unsigned GRID_STEP = arff_pkg::GRID_STEP_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [arff_pkg::S_DATA_W-1:0] s_tdata,   // rect_width, rect_height
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [arff_pkg::M_DATA_W-1:0] m_tdata,   // origin_x, origin_y
	output logic                          m_tuser    // status
);
	import arff_pkg::*;

	localparam int unsigned RW = $clog2(SIDE);
	localparam int unsigned CW = $clog2(SIDE + GRID_STEP + 256) + 1;

	arff_state_t state_q;

	logic [RW-1:0]    clr_q;
	logic [DIM_W-1:0] w_q;
	logic [DIM_W-1:0] h_q;
	logic [CW-1:0]    cx_q;
	logic [CW-1:0]    cy_q;
	logic [CW-1:0]    row_q;
	logic [SIDE-1:0]  mask_q;

	logic [DIM_W-1:0] res_x_q;
	logic [DIM_W-1:0] res_y_q;
	logic             res_st_q;
	logic             out_valid_q;

	arff_mem_ctl_t    mem_ctl;
	logic [RW-1:0]    mem_addr;
	logic [SIDE-1:0]  mem_wdata;
	logic [SIDE-1:0]  mem_rdata;

	logic [CW-1:0]    cx_end;
	logic [CW-1:0]    cy_end;
	logic             fit_y;
	logic             fit_x;
	logic             last_row;
	logic             hit;
	logic [SIDE-1:0]  mask_next;

	arff_bitmap #(
		.SIDE (SIDE)
	) u_bitmap (
		.clk   (clk),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// candidate bounds
	assign cx_end   = cx_q + CW'(w_q);
	assign cy_end   = cy_q + CW'(h_q);
	assign fit_y    = cy_end <= CW'(SIDE);
	assign fit_x    = cx_end <= CW'(SIDE);
	assign last_row = (row_q + CW'(1)) == cy_end;
	assign hit      = |(mem_rdata & mask_q);

	// column mask of the current candidate
	always_comb begin
		for (int i = 0; i < SIDE; i++) begin
			mask_next[i] = (CW'(i) >= cx_q) && (CW'(i) < cx_end);
		end
	end

	// memory access per state
	always_comb begin
		mem_ctl   = '0;
		mem_addr  = row_q[RW-1:0];
		mem_wdata = mem_rdata | mask_q;
		case (state_q)
			ST_CLEAR: begin
				mem_ctl.en = 1'b1;
				mem_ctl.we = 1'b1;
				mem_addr   = clr_q;
				mem_wdata  = '0;
			end
			ST_SCAN_RD, ST_MARK_RD: begin
				mem_ctl.en = 1'b1;
			end
			ST_MARK_WR: begin
				mem_ctl.en = 1'b1;
				mem_ctl.we = 1'b1;
			end
			default: begin
				mem_ctl = '0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			res_st_q <= STATUS_OK;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + RW'(1);
					if (clr_q == RW'(SIDE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						w_q     <= s_tdata[DIM_W-1:0];
						h_q     <= s_tdata[2*DIM_W-1:DIM_W];
						cx_q    <= '0;
						cy_q    <= '0;
						state_q <= ST_CAND;
					end
				end
				ST_CAND: begin
					if (!fit_y) begin
						res_x_q  <= '0;
						res_y_q  <= '0;
						res_st_q <= STATUS_FULL;
						state_q  <= ST_OUT;
					end else if (!fit_x) begin
						cx_q <= '0;
						cy_q <= cy_q + CW'(GRID_STEP);
					end else if (w_q == '0 || h_q == '0) begin
						// empty rectangle is always free, nothing to mark
						res_x_q  <= cx_q[DIM_W-1:0];
						res_y_q  <= cy_q[DIM_W-1:0];
						res_st_q <= STATUS_OK;
						state_q  <= ST_OUT;
					end else begin
						mask_q  <= mask_next;
						row_q   <= cy_q;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CHK;
				end
				ST_SCAN_CHK: begin
					if (hit) begin
						cx_q    <= cx_q + CW'(GRID_STEP);
						state_q <= ST_CAND;
					end else if (last_row) begin
						row_q   <= cy_q;
						state_q <= ST_MARK_RD;
					end else begin
						row_q   <= row_q + CW'(1);
						state_q <= ST_SCAN_RD;
					end
				end
				ST_MARK_RD: begin
					state_q <= ST_MARK_WR;
				end
				ST_MARK_WR: begin
					if (last_row) begin
						res_x_q  <= cx_q[DIM_W-1:0];
						res_y_q  <= cy_q[DIM_W-1:0];
						res_st_q <= STATUS_OK;
						state_q  <= ST_OUT;
					end else begin
						row_q   <= row_q + CW'(1);
						state_q <= ST_MARK_RD;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && (!out_valid_q || m_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [DIM_W-1:0] out_x_q;
	logic [DIM_W-1:0] out_y_q;
	logic             out_st_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || m_tready)) begin
			out_x_q  <= res_x_q;
			out_y_q  <= res_y_q;
			out_st_q <= res_st_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_y_q, out_x_q};
	assign m_tuser  = out_st_q;

	// bitmap is written only by the clearing pass or the marking step
	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_ctl.en && mem_ctl.we) |-> (state_q == ST_CLEAR || state_q == ST_MARK_WR))
		else $error("bitmap written outside clear or mark");

	// a row is written back only right after it was read
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARK_WR) |-> $past(state_q == ST_MARK_RD))
		else $error("mark write without preceding read");

	// a full result carries a zero origin
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == STATUS_FULL) |-> (m_tdata == '0))
		else $error("full result with nonzero origin");

	// no item is taken while the clearing pass runs
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_tready)
		else $error("input ready during clearing pass");

endmodule

[bench/atlas_rect_first_fit_allocator_tb.sv]
`timescale 1ns / 1ps

module atlas_rect_first_fit_allocator_tb;

	import arff_pkg::*;

	localparam int SIDE       = SIDE_DEF;
	localparam int STEP       = GRID_STEP_DEF;
	localparam int HOLD_LEN   = 5000;
	localparam int TAIL_WAIT  = 1000;
	localparam int BASE_LIMIT = 500000;

	typedef struct packed {
		logic [7:0] w;
		logic [7:0] h;
		logic       drain;
	} rect_req_t;

	typedef struct packed {
		logic [7:0] origin_x;
		logic [7:0] origin_y;
		logic       status;
	} alloc_res_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;   // rect_width, rect_height
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;         // origin_x, origin_y
	logic                m_tuser;         // status

	// own copy of the occupancy bitmap, one vector per row
	logic [SIDE-1:0] occ_rows [0:SIDE-1];

	rect_req_t  pending_reqs [$];
	alloc_res_t origins_due [$];

	int     n_accepted  = 0;
	int     n_results   = 0;
	int     mismatches  = 0;
	int     cycle_count = 0;
	longint work_budget = 0;
	int     hold_cnt    = 0;
	logic   hold_done   = 1'b0;
	logic   hold_active;

	atlas_rect_first_fit_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	// first-fit scan over grid origins, x first, then y
	task automatic predict_alloc(input logic [7:0] w, input logic [7:0] h);
		logic [SIDE-1:0] ones;
		logic [SIDE-1:0] span;
		alloc_res_t res;
		int cx, cy, j, tried;
		bit found, clash;
		ones  = '1;
		res   = '{origin_x: 8'd0, origin_y: 8'd0, status: STATUS_FULL};
		found = 1'b0;
		tried = 0;
		for (cy = 0; cy + h <= SIDE && !found; cy += STEP) begin
			for (cx = 0; cx + w <= SIDE && !found; cx += STEP) begin
				tried++;
				span  = (ones >> (SIDE - w)) << cx;
				clash = 1'b0;
				for (j = 0; j < h && !clash; j++)
					if ((occ_rows[cy + j] & span) != '0)
						clash = 1'b1;
				if (!clash) begin
					found = 1'b1;
					for (j = 0; j < h; j++)
						occ_rows[cy + j] = occ_rows[cy + j] | span;
					res = '{origin_x: cx[7:0], origin_y: cy[7:0], status: STATUS_OK};
				end
			end
		end
		// cycle allowance for this request, used by the run limit
		work_budget += longint'(tried) * (1 + 2 * h) + 2 * h + 16;
		origins_due = {origins_due, res};
	endtask

	task automatic push_req(input logic [7:0] w, input logic [7:0] h, input logic drain);
		rect_req_t req;
		req          = '{w: w, h: h, drain: drain};
		pending_reqs = {pending_reqs, req};
	endtask

	// mostly small sizes so the surface takes many allocations
	function automatic logic [7:0] rand_dim(input int pick);
		if (pick < 5)
			return 8'd0;
		else if (pick < 70)
			return 8'($urandom_range(1, 16));
		else if (pick < 85)
			return 8'($urandom_range(17, 40));
		else if (pick < 95)
			return 8'($urandom_range(41, 127));
		return 8'($urandom_range(128, 255));
	endfunction

	// sender: offer pending requests, idle at random, drain on marked items
	always @(posedge clk or negedge arst_n) begin : drive_requests
		logic      offer;
		int        took;
		logic      calm;
		rect_req_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			offer = s_tvalid;
			took  = 0;
			if (s_tvalid && s_tready) begin
				predict_alloc(s_tdata[7:0], s_tdata[15:8]);
				took  = 1;
				offer = 1'b0;
			end
			n_accepted <= n_accepted + took;
			calm = (n_accepted >= 40 && n_accepted < 80);
			if (!offer && pending_reqs.size() != 0) begin
				if (!(pending_reqs[0].drain && n_results != n_accepted + took)
				    && (calm || $urandom_range(0, 99) >= 31)) begin
					nxt = pending_reqs.pop_front();
					s_tdata <= {nxt.h, nxt.w};
					offer = 1'b1;
				end
			end
			s_tvalid <= offer;
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt  <= 0;
			hold_done <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (!hold_done && n_results >= 100) begin
			hold_cnt  <= HOLD_LEN;
			hold_done <= 1'b1;
		end
	end

	assign hold_active = (hold_cnt != 0);

	// receiver: compare each result transfer with the oldest expected origin
	always @(posedge clk or negedge arst_n) begin : check_results
		alloc_res_t want;
		alloc_res_t got;
		logic       calm;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{origin_x: m_tdata[7:0], origin_y: m_tdata[15:8], status: m_tuser};
				n_results <= n_results + 1;
				if (origins_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: x=%0d y=%0d status=%0b",
							got.origin_x, got.origin_y, got.status);
				end else begin
					want = origins_due.pop_front();
					if (got.origin_x !== want.origin_x || got.origin_y !== want.origin_y
					    || got.status !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: expected x=%0d y=%0d status=%0b, got x=%0d y=%0d status=%0b",
								n_results, want.origin_x, want.origin_y, want.status,
								got.origin_x, got.origin_y, got.status);
					end
				end
			end
			calm = (n_results >= 40 && n_results < 80);
			m_tready <= !hold_active && (calm || $urandom_range(0, 99) >= 31);
		end
	end

	// run limit grows with the work of the accepted requests
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > BASE_LIMIT + 4 * work_budget) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		int i;
		for (i = 0; i < SIDE; i++)
			occ_rows[i] = '0;

		// directed: extremes, empty rectangles, border and oversize cases
		push_req(8'd1,   8'd1,   1'b0);
		push_req(8'd0,   8'd7,   1'b0);
		push_req(8'd9,   8'd0,   1'b0);
		push_req(8'd0,   8'd0,   1'b0);
		push_req(8'd255, 8'd255, 1'b0);
		push_req(8'd16,  8'd16,  1'b0);
		push_req(8'd17,  8'd1,   1'b0);
		push_req(8'd255, 8'd1,   1'b0);
		push_req(8'd1,   8'd255, 1'b0);
		push_req(8'd128, 8'd128, 1'b0);
		push_req(8'd170, 8'd85,  1'b0);
		push_req(8'd85,  8'd170, 1'b0);
		push_req(8'd16,  8'd240, 1'b0);
		push_req(8'd240, 8'd16,  1'b0);
		push_req(8'd32,  8'd32,  1'b0);
		push_req(8'd2,   8'd4,   1'b0);
		push_req(8'd8,   8'd64,  1'b0);
		push_req(8'd64,  8'd8,   1'b0);
		push_req(8'd15,  8'd15,  1'b0);
		push_req(8'd254, 8'd254, 1'b0);

		// random part, drained once early and once late
		for (i = 0; i < 120; i++)
			push_req(rand_dim($urandom_range(0, 99)), rand_dim($urandom_range(0, 99)),
				i == 0 || i == 90);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || s_tvalid || n_results != n_accepted)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		if (mismatches == 0 && origins_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
